// File: rtl/core/grf_pkg.sv
// shared types, constants and codes of the glyph renderer
package grf_pkg;

  // default sizes for the top level parameters
  localparam int unsigned FrameBytesDef  = 512;
  localparam int unsigned ColumnBytesDef = 4;
  localparam int unsigned FontBytesDef   = 4096;

  // font header and per-glyph header size in bytes
  localparam int unsigned HdrBytes  = 4;
  // pixels per frame byte
  localparam int unsigned PixPerByte = 8;
  localparam logic [9:0]  CursorMax  = 10'd1023;

  // font pointer wide enough for header base plus 16-bit jump before wrap
  localparam int unsigned FpW = 17;
  // frame address before range check
  localparam int unsigned FaW = 16;

  // field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned AddrW   = 12;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CursXW  = 10;
  localparam int unsigned CursYW  = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HeightW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  typedef enum logic [OpW-1:0] {
    OP_FONT_WR = 2'd0,
    OP_DRAW    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FONT    = 2'd1,
    ST_OFF_SCREEN = 2'd2,
    ST_NO_CHAR    = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FONT_LOADED = 2'd0,
    CFG_FONT_HEIGHT = 2'd1,
    CFG_FIRST_CHAR  = 2'd2,
    CFG_CHAR_COUNT  = 2'd3
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    font_wr;
    logic    clr_start;
    logic    clr_step;
    logic    frm_rd;
    logic    cap_rd;
    logic    hdr_start;
    logic    reduce;
    logic    hdr_step;
    logic    base_start;
    logic    glyph_rd;
    logic    glyph_wr;
    logic    res_load;
    status_e res_status;
    logic    res_adv;
    logic    res_rd;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic font_addr_ok;
    logic frame_addr_ok;
    logic loaded;
    logic in_range;
    logic fp_ge;
    logic hdr_done;
    logic count_zero;
    logic fa_oob;
    logic last_byte;
    logic clr_last;
  } sts_t;

endpackage

// File: rtl/core/grf_stream_if.sv
// valid/ready channels for operations and results
interface grf_in_if import grf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [AddrW-1:0]  address;
  logic [ByteW-1:0]  font_data;
  logic [ByteW-1:0]  char_code;
  logic [CursXW-1:0] cursor_x;
  logic [CursYW-1:0] cursor_y;

  modport source (
    output valid, operation, address, font_data, char_code, cursor_x, cursor_y,
    input  ready
  );
  modport sink (
    input  valid, operation, address, font_data, char_code, cursor_x, cursor_y,
    output ready
  );
endinterface

interface grf_out_if import grf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CursXW-1:0]  next_cursor_x;
  logic [ByteW-1:0]   read_data;

  modport source (
    output valid, status, next_cursor_x, read_data,
    input  ready
  );
  modport sink (
    input  valid, status, next_cursor_x, read_data,
    output ready
  );
endinterface

// File: rtl/core/grf_ram.sv
// generic single-write, single-read ram with registered read data
module grf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/grf_ctrl.sv
// sequencing state machine of the glyph renderer
module grf_ctrl import grf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_HRED,
    S_HDR,
    S_BASE,
    S_BRED,
    S_GRD,
    S_GWR,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    adv_q, adv_d;
  logic    rd_q, rd_d;
  logic    clr_op_q, clr_op_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    st_d       = st_q;
    adv_d      = adv_q;
    rd_d       = rd_q;
    clr_op_d   = clr_op_q;

    cmd_o.res_status = st_q;
    cmd_o.res_adv    = adv_q;
    cmd_o.res_rd     = rd_q;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d  = clr_op_q ? S_FINISH : S_IDLE;
          clr_op_d = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          st_d    = ST_OK;
          adv_d   = 1'b0;
          rd_d    = 1'b0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_FONT_WR: begin
            cmd_o.font_wr = sts_i.font_addr_ok;
            state_d       = S_FINISH;
          end
          OP_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            clr_op_d        = 1'b1;
            state_d         = S_CLEAR;
          end
          OP_READ: begin
            if (sts_i.frame_addr_ok) begin
              cmd_o.frm_rd = 1'b1;
              rd_d         = 1'b1;
              state_d      = S_RDWAIT;
            end else begin
              st_d    = ST_OFF_SCREEN;
              state_d = S_FINISH;
            end
          end
          OP_DRAW: begin
            if (!sts_i.loaded) begin
              st_d    = ST_NO_FONT;
              state_d = S_FINISH;
            end else if (!sts_i.in_range) begin
              st_d    = ST_NO_CHAR;
              state_d = S_FINISH;
            end else begin
              cmd_o.hdr_start = 1'b1;
              state_d         = S_HRED;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_RDWAIT: begin
        cmd_o.cap_rd = 1'b1;
        state_d      = S_FINISH;
      end
      S_HRED: begin
        if (sts_i.fp_ge) begin
          cmd_o.reduce = 1'b1;
        end else begin
          state_d = S_HDR;
        end
      end
      S_HDR: begin
        cmd_o.hdr_step = 1'b1;
        if (sts_i.hdr_done) begin
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        cmd_o.base_start = 1'b1;
        state_d          = S_BRED;
      end
      S_BRED: begin
        if (sts_i.fp_ge) begin
          cmd_o.reduce = 1'b1;
        end else if (sts_i.count_zero) begin
          adv_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_GRD;
        end
      end
      S_GRD: begin
        if (sts_i.fa_oob) begin
          st_d    = ST_OFF_SCREEN;
          state_d = S_FINISH;
        end else begin
          cmd_o.glyph_rd = 1'b1;
          state_d        = S_GWR;
        end
      end
      S_GWR: begin
        cmd_o.glyph_wr = 1'b1;
        if (sts_i.last_byte) begin
          adv_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_GRD;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      st_q        <= ST_OK;
      adv_q       <= 1'b0;
      rd_q        <= 1'b0;
      clr_op_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      adv_q       <= adv_d;
      rd_q        <= rd_d;
      clr_op_q    <= clr_op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.glyph_wr |-> $past(cmd_o.glyph_rd))
    else $error("glyph write without preceding read");

  a_base_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.base_start |-> $past(sts_i.hdr_done))
    else $error("glyph base computed before header complete");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_step |-> (!in_ready_o && !cmd_o.res_load))
    else $error("transfer or result during frame clear");

  a_offscreen_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.res_load && cmd_o.res_status == ST_OFF_SCREEN)
      |-> (sts_i.op == OP_DRAW || sts_i.op == OP_READ))
    else $error("off-screen status on font write or clear");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_o || out_ready_i))
    else $error("result overwrites one not yet taken");
`endif

endmodule

// File: rtl/core/grf_dp.sv
// item, configuration, font and frame memories, address arithmetic
module grf_dp import grf_pkg::*; #(
  parameter int unsigned FRAME_BYTES  = FrameBytesDef,
  parameter int unsigned COLUMN_BYTES = ColumnBytesDef,
  parameter int unsigned FONT_BYTES   = FontBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic [OpW-1:0]     operation_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic [ByteW-1:0]   font_data_i,
  input  logic [ByteW-1:0]   char_code_i,
  input  logic [CursXW-1:0]  cursor_x_i,
  input  logic [CursYW-1:0]  cursor_y_i,
  output logic [StatusW-1:0] status_o,
  output logic [CursXW-1:0]  next_cursor_x_o,
  output logic [ByteW-1:0]   read_data_o,
  input  cmd_t               cmd_i,
  output sts_t               sts_o
);

  localparam int unsigned FontAw  = $clog2(FONT_BYTES);
  localparam int unsigned FrameAw = $clog2(FRAME_BYTES);

  // configuration registers
  logic               loaded_q;
  logic [HeightW-1:0] height_q;
  logic [ByteW-1:0]   first_q;
  logic [ByteW-1:0]   count_cfg_q;

  // latched item
  op_e               op_q;
  logic [AddrW-1:0]  addr_q;
  logic [ByteW-1:0]  data_q;
  logic [ByteW-1:0]  code_q;
  logic [CursXW-1:0] cx_q;
  logic [CursYW-1:0] cy_q;

  // draw state
  logic [FpW-1:0]   fp_q;
  logic [2:0]       hk_q;
  logic [31:0]      hdr_q;
  logic [ByteW-1:0] col_q;
  logic [3:0]       row_q;
  logic [ByteW-1:0] idx_q;
  logic [ByteW-1:0] rdat_q;

  logic [FrameAw-1:0] clr_cnt_q;

  // result register
  status_e           res_st_q;
  logic [CursXW-1:0] res_nx_q;
  logic [ByteW-1:0]  res_rd_q;

  logic [ByteW-1:0]   rel;
  logic [FpW-1:0]     fp_inc, hdr_addr, base_addr, font_waddr;
  logic [FaW-1:0]     fa, item_fa;
  logic [4:0]         row_n;
  logic [CursXW:0]    nx_sum;
  logic [CursXW-1:0]  nx_sat;
  logic [ByteW-1:0]   font_rdata, frame_rdata, glyph_len;
  logic               font_re, frame_we, frame_re;
  logic [FrameAw-1:0] frame_waddr, frame_raddr;
  logic [ByteW-1:0]   frame_wdata;

  assign glyph_len  = hdr_q[15:8];
  assign rel        = code_q - first_q;
  assign fp_inc     = (fp_q == FpW'(FONT_BYTES - 1)) ? '0 : fp_q + FpW'(1);
  assign hdr_addr   = FpW'(HdrBytes) + FpW'(rel) * FpW'(HdrBytes);
  assign base_addr  = FpW'(HdrBytes) + FpW'(count_cfg_q) * FpW'(HdrBytes)
                    + FpW'(hdr_q[31:16]);
  assign font_waddr = FpW'(addr_q);
  assign item_fa    = FaW'(addr_q);

  // column-major frame address of the current glyph byte
  assign fa = FaW'(COLUMN_BYTES) * (FaW'(cx_q) + FaW'(col_q))
            + FaW'(cy_q) + FaW'(row_q);

  assign row_n  = {1'b0, row_q} + 5'd1;
  assign nx_sum = {1'b0, cx_q} + (CursXW + 1)'(hdr_q[7:0]);
  assign nx_sat = (nx_sum > {1'b0, CursorMax}) ? CursorMax : nx_sum[CursXW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= 1'b0;
      height_q    <= HeightW'(8);
      first_q     <= ByteW'(32);
      count_cfg_q <= '0;
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_FONT_LOADED: loaded_q    <= cfg_data_i[0];
          CFG_FONT_HEIGHT: height_q    <= cfg_data_i[HeightW-1:0];
          CFG_FIRST_CHAR:  first_q     <= cfg_data_i;
          CFG_CHAR_COUNT:  count_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + FrameAw'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= op_e'(operation_i);
      addr_q <= address_i;
      data_q <= font_data_i;
      code_q <= char_code_i;
      cx_q   <= cursor_x_i;
      cy_q   <= cursor_y_i;
    end

    if (cmd_i.hdr_start) begin
      fp_q <= hdr_addr;
      hk_q <= '0;
    end else if (cmd_i.reduce) begin
      fp_q <= fp_q - FpW'(FONT_BYTES);
    end else if (cmd_i.base_start) begin
      fp_q  <= base_addr;
      col_q <= '0;
      row_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.hdr_step) begin
      if (hk_q != 3'd4) begin
        fp_q <= fp_inc;
      end
      if (hk_q != 3'd0) begin
        hdr_q <= {hdr_q[23:0], font_rdata};
      end
      hk_q <= hk_q + 3'd1;
    end else if (cmd_i.glyph_wr) begin
      fp_q  <= fp_inc;
      idx_q <= idx_q + ByteW'(1);
      // next column once the font height is covered
      if ({row_n, 3'b000} >= {1'b0, height_q}) begin
        col_q <= col_q + ByteW'(1);
        row_q <= '0;
      end else begin
        row_q <= row_n[3:0];
      end
    end

    if (cmd_i.cap_rd) begin
      rdat_q <= frame_rdata;
    end

    if (cmd_i.res_load) begin
      res_st_q <= cmd_i.res_status;
      res_nx_q <= cmd_i.res_adv ? nx_sat : cx_q;
      res_rd_q <= cmd_i.res_rd ? rdat_q : '0;
    end
  end

  assign font_re = cmd_i.glyph_rd | (cmd_i.hdr_step & (hk_q != 3'd4));

  grf_ram #(
    .WIDTH (ByteW),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.font_wr),
    .waddr_i (font_waddr[FontAw-1:0]),
    .wdata_i (data_q),
    .re_i    (font_re),
    .raddr_i (fp_q[FontAw-1:0]),
    .rdata_o (font_rdata)
  );

  assign frame_we    = cmd_i.clr_step | cmd_i.glyph_wr;
  assign frame_waddr = cmd_i.clr_step ? clr_cnt_q : fa[FrameAw-1:0];
  assign frame_wdata = cmd_i.clr_step ? '0 : (frame_rdata | font_rdata);
  assign frame_re    = cmd_i.glyph_rd | cmd_i.frm_rd;
  assign frame_raddr = cmd_i.glyph_rd ? fa[FrameAw-1:0] : item_fa[FrameAw-1:0];

  grf_ram #(
    .WIDTH (ByteW),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (frame_wdata),
    .re_i    (frame_re),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  assign sts_o.op            = op_q;
  assign sts_o.font_addr_ok  = font_waddr < FpW'(FONT_BYTES);
  assign sts_o.frame_addr_ok = item_fa < FaW'(FRAME_BYTES);
  assign sts_o.loaded        = loaded_q;
  assign sts_o.in_range      = (code_q >= first_q) && (rel < count_cfg_q);
  assign sts_o.fp_ge         = fp_q >= FpW'(FONT_BYTES);
  assign sts_o.hdr_done      = hk_q == 3'd4;
  assign sts_o.count_zero    = glyph_len == '0;
  assign sts_o.fa_oob        = fa >= FaW'(FRAME_BYTES);
  assign sts_o.last_byte     = idx_q == glyph_len - ByteW'(1);
  assign sts_o.clr_last      = clr_cnt_q == FrameAw'(FRAME_BYTES - 1);

  assign status_o        = res_st_q;
  assign next_cursor_x_o = res_nx_q;
  assign read_data_o     = res_rd_q;

endmodule

// File: rtl/core/glyph_render_to_framebuffer_core.sv
// top level of the proportional-font glyph renderer into a byte-column frame buffer
//
//  channel   dir   handshake            payload
//  in_i      in    valid/ready          operation, address, font_data, char_code,
//                                       cursor_x, cursor_y
//  out_o     out   valid/ready          status, next_cursor_x, read_data
//  cfg       in    cfg_we_i, no stall   cfg_idx_i, cfg_data_i
//
//  one item at a time; the shared font and frame memory ports set the pace
//  draw: a frame read-modify-write per glyph byte, plus font-size subtractions
//    while wrapping font addresses
//  after reset the frame buffer is zeroed, one byte a cycle, with no input
//    transfer taken meanwhile; config writes are taken as ever
//  the next input transfer is taken while a result still waits on out_o
module glyph_render_to_framebuffer_core import grf_pkg::*; #(
  parameter int unsigned FRAME_BYTES  = FrameBytesDef,
  parameter int unsigned COLUMN_BYTES = ColumnBytesDef,
  parameter int unsigned FONT_BYTES   = FontBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  grf_in_if.sink             in_i,
  grf_out_if.source          out_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes the operation, walks header, glyph bytes and clear sweep
  grf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: config registers, memories, address math, result register
  grf_dp #(
    .FRAME_BYTES  (FRAME_BYTES),
    .COLUMN_BYTES (COLUMN_BYTES),
    .FONT_BYTES   (FONT_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (in_i.operation),
    .address_i       (in_i.address),
    .font_data_i     (in_i.font_data),
    .char_code_i     (in_i.char_code),
    .cursor_x_i      (in_i.cursor_x),
    .cursor_y_i      (in_i.cursor_y),
    .status_o        (out_o.status),
    .next_cursor_x_o (out_o.next_cursor_x),
    .read_data_o     (out_o.read_data),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the glyph renderer core: directed and random traffic with a predictor
`timescale 1ns / 100ps

module tb_top import grf_pkg::*; ();

  localparam int unsigned FrameBytes  = FrameBytesDef;
  localparam int unsigned ColumnBytes = ColumnBytesDef;
  localparam int unsigned FontBytes   = FontBytesDef;

  // one operation as offered on the input channel
  typedef struct {
    op_e               op;
    logic [AddrW-1:0]  addr;
    logic [ByteW-1:0]  font_byte;
    logic [ByteW-1:0]  code;
    logic [CursXW-1:0] cx;
    logic [CursYW-1:0] cy;
  } render_op_t;

  // one result as delivered on the output channel
  typedef struct {
    status_e           status;
    logic [CursXW-1:0] next_x;
    logic [ByteW-1:0]  rd;
  } render_res_t;

  // traffic shaping per phase
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SNK_STALL,
    FLOW_BOTH
  } flow_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CfgW-1:0]  cfg_data;

  grf_in_if  in_bus ();
  grf_out_if out_bus ();

  glyph_render_to_framebuffer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // register copies, shared by the stimulus planner and the predictor
  // (only ever changed while nothing is in flight)
  logic               reg_loaded = 1'b0;
  logic [HeightW-1:0] reg_height = 7'd8;
  logic [ByteW-1:0]   reg_first  = 8'd32;
  logic [ByteW-1:0]   reg_count  = 8'd0;

  // predictor state: font memory and frame buffer as the block should hold them
  logic [ByteW-1:0] font_mem  [FontBytes];
  logic [ByteW-1:0] frame_mem [FrameBytes] = '{default: '0};

  // planner view of the font, ahead of the predictor by whatever is still queued
  logic [ByteW-1:0] plan_font    [FontBytes];
  bit               plan_written [FontBytes];

  render_op_t  op_backlog   [$];
  render_res_t owed_results [$];

  flow_e       flow = FLOW_FREE;
  bit          in_taken;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned mismatches;
  int unsigned last_fa;

  // ---------------------------------------------------------------------------
  // predictor: apply one accepted operation, return the result it should give
  // ---------------------------------------------------------------------------
  function automatic render_res_t render_op(input render_op_t it);
    render_res_t res;
    int unsigned code, cx, cy, slot, jump, glen, adv, base, col, row, fa, nx, k;
    code = it.code;
    cx   = it.cx;
    cy   = it.cy;
    res.status = ST_OK;
    res.next_x = it.cx;
    res.rd     = '0;
    case (it.op)
      OP_FONT_WR: begin
        if (it.addr < FontBytes) font_mem[it.addr] = it.font_byte;
      end
      OP_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = '0;
      end
      OP_READ: begin
        // reads past the buffer end come back empty and flagged
        if (it.addr < FrameBytes) res.rd = frame_mem[it.addr];
        else res.status = ST_OFF_SCREEN;
      end
      default: begin
        if (!reg_loaded) begin
          res.status = ST_NO_FONT;
        end else if (code < reg_first || code - reg_first >= reg_count) begin
          res.status = ST_NO_CHAR;
        end else begin
          // glyph header: big-endian jump, byte count, advance
          slot = HdrBytes + HdrBytes * (code - reg_first);
          jump = {font_mem[slot % FontBytes], font_mem[(slot + 1) % FontBytes]};
          glen = font_mem[(slot + 2) % FontBytes];
          adv  = font_mem[(slot + 3) % FontBytes];
          base = HdrBytes + HdrBytes * reg_count + jump;
          col  = 0;
          row  = 0;
          for (k = 0; k < glen; k++) begin
            fa = ColumnBytes * (cx + col) + cy + row;
            if (fa >= FrameBytes) begin
              // partial glyph stays in the frame, cursor does not move
              res.status = ST_OFF_SCREEN;
              return res;
            end
            frame_mem[fa] = frame_mem[fa] | font_mem[(base + k) % FontBytes];
            row++;
            if (PixPerByte * row >= reg_height) begin
              col++;
              row = 0;
            end
          end
          nx = cx + adv;
          res.next_x = (nx > CursorMax) ? CursorMax : nx[CursXW-1:0];
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // true when a draw only touches font bytes that were already written
  function automatic bit plan_draw_ok(input int unsigned code, input int unsigned cx,
                                      input int unsigned cy);
    int unsigned slot, jump, glen, base, col, row, fa, k;
    if (!reg_loaded || code < reg_first || code - reg_first >= reg_count) return 1'b1;
    slot = HdrBytes + HdrBytes * (code - reg_first);
    for (k = 0; k < HdrBytes; k++) begin
      if (!plan_written[(slot + k) % FontBytes]) return 1'b0;
    end
    jump = {plan_font[slot % FontBytes], plan_font[(slot + 1) % FontBytes]};
    glen = plan_font[(slot + 2) % FontBytes];
    base = HdrBytes + HdrBytes * reg_count + jump;
    col  = 0;
    row  = 0;
    // the byte at the off-screen stop must be written too, in case it is fetched early
    for (k = 0; k < glen; k++) begin
      if (!plan_written[(base + k) % FontBytes]) return 1'b0;
      fa = ColumnBytes * (cx + col) + cy + row;
      if (fa >= FrameBytes) return 1'b1;
      row++;
      if (PixPerByte * row >= reg_height) begin
        col++;
        row = 0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void push_op(input op_e op, input int unsigned addr,
                                  input int unsigned data, input int unsigned code,
                                  input int unsigned cx, input int unsigned cy);
    render_op_t it;
    it.op        = op;
    it.addr      = addr[AddrW-1:0];
    it.font_byte = data[ByteW-1:0];
    it.code      = code[ByteW-1:0];
    it.cx        = cx[CursXW-1:0];
    it.cy        = cy[CursYW-1:0];
    if (op == OP_FONT_WR) begin
      plan_font[it.addr]    = it.font_byte;
      plan_written[it.addr] = 1'b1;
    end
    op_backlog.push_back(it);
  endfunction

  // fields an operation does not use are filled at random
  function automatic void put_font(input int unsigned addr, input int unsigned data);
    push_op(OP_FONT_WR, addr, data, $urandom, $urandom, $urandom);
  endfunction

  function automatic void put_read(input int unsigned addr);
    push_op(OP_READ, addr, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic void put_clear();
    push_op(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // a draw that would read unwritten font bytes becomes a code outside the font
  function automatic void put_draw(input int unsigned code, input int unsigned cx,
                                   input int unsigned cy);
    if (!plan_draw_ok(code, cx, cy)) code = (reg_first > 0) ? 0 : 255;
    push_op(OP_DRAW, $urandom, $urandom, code, cx, cy);
    last_fa = ColumnBytes * cx + cy;
  endfunction

  // all queued work done and every result back, plus a short settle
  task automatic wait_drained();
    while (op_backlog.size() != 0 || owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CfgW-1:0];
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_FONT_LOADED: reg_loaded = value[0];
      CFG_FONT_HEIGHT: reg_height = value[HeightW-1:0];
      CFG_FIRST_CHAR:  reg_first  = value[ByteW-1:0];
      default:         reg_count  = value[ByteW-1:0];
    endcase
  endtask

  // one random phase: registers, a small font, then a mix of operations
  task automatic run_phase(input flow_e mode, input bit loaded, input int unsigned height,
                           input int unsigned first, input int unsigned count,
                           input int unsigned glyphs, input int unsigned ops,
                           input int unsigned big_len, input bit pause_mid,
                           input bit long_hold);
    int unsigned codes [$];
    int unsigned code, hi, glen, loc, jump, slot, cx, cy, pick, near, g, n, k;
    wait_drained();
    flow = mode;
    write_reg(CFG_FONT_LOADED, loaded);
    write_reg(CFG_FONT_HEIGHT, height);
    write_reg(CFG_FIRST_CHAR, first);
    write_reg(CFG_CHAR_COUNT, count);
    // receiver holds off while the sender keeps offering, so the core backs up
    if (long_hold) hold_req = 1'b1;

    // glyph headers and bitmaps, bitmaps placed anywhere (wrapping the font end too)
    for (g = 0; g < glyphs && count != 0; g++) begin
      hi   = (first + count - 1 > 255) ? 255 : first + count - 1;
      code = $urandom_range(hi, first);
      if (g == 0 && big_len != 0) glen = big_len;
      else if ($urandom_range(3, 0) == 0) glen = $urandom_range(40, 11);
      else glen = $urandom_range(10, 0);
      loc  = $urandom_range(FontBytes - 1, 0);
      jump = ((loc + 2 * FontBytes - HdrBytes - HdrBytes * count) % FontBytes)
             + FontBytes * $urandom_range(15, 0);
      slot = HdrBytes + HdrBytes * (code - first);
      put_font(slot, jump >> 8);
      put_font(slot + 1, jump & 8'hFF);
      put_font(slot + 2, glen);
      put_font(slot + 3, $urandom_range(255, 0));
      for (k = 0; k < glen; k++) put_font((loc + k) % FontBytes, $urandom_range(255, 0));
      codes.push_back(code);
    end

    for (n = 0; n < ops; n++) begin
      // sender pause: nothing new until every result is back
      if (pause_mid && n == ops / 2) wait_drained();
      pick = $urandom_range(99, 0);
      cx   = ($urandom_range(4, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(127, 0);
      cy   = $urandom_range(3, 0);
      if (pick < 55 && codes.size() != 0) begin
        put_draw(codes[$urandom_range(codes.size() - 1, 0)], cx, cy);
      end else if (pick < 67) begin
        put_draw($urandom_range(255, 0), cx, cy);
      end else if (pick < 80) begin
        near = $urandom_range(2, 0);
        if (near == 0) put_read($urandom_range(4095, 0));
        else if (near == 1) put_read($urandom_range(FrameBytes - 1, 0));
        else put_read((last_fa + $urandom_range(12, 0)) % 4096);
      end else if (pick < 83) begin
        put_clear();
      end else begin
        // stray font writes, now and then over live headers
        put_font($urandom_range(4095, 0), $urandom_range(255, 0));
      end
    end
  endtask

  function automatic bit idle_now(input bit sink_side);
    int unsigned pct;
    case (flow)
      FLOW_SRC_IDLE:  pct = sink_side ? 0 : 75;
      FLOW_SNK_STALL: pct = sink_side ? 75 : 0;
      FLOW_BOTH:      pct = 32;
      default:        pct = 0;
    endcase
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents the oldest queued operation, holds it until its transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!in_bus.valid || in_taken) begin
      if (op_backlog.size() != 0 && !idle_now(1'b0)) begin
        in_bus.valid     <= 1'b1;
        in_bus.operation <= op_backlog[0].op;
        in_bus.address   <= op_backlog[0].addr;
        in_bus.font_data <= op_backlog[0].font_byte;
        in_bus.char_code <= op_backlog[0].code;
        in_bus.cursor_x  <= op_backlog[0].cx;
        in_bus.cursor_y  <= op_backlog[0].cy;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    out_bus.ready <= (hold_left == 0) && !idle_now(1'b1);
  end

  // long hold-off counter, armed by the stimulus
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: input transfers feed the predictor, output transfers are checked
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    render_res_t want;
    in_taken = 1'b0;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      owed_results.push_back(render_op(op_backlog.pop_front()));
      in_taken = 1'b1;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (owed_results.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d next_x %0d data %02h",
                               out_bus.status, out_bus.next_cursor_x, out_bus.read_data));
      end else begin
        want = owed_results.pop_front();
        if (out_bus.status !== want.status || out_bus.next_cursor_x !== want.next_x ||
            out_bus.read_data !== want.rd) begin
          note_failure($sformatf(
            "status %0d/%0d next_x %0d/%0d data %02h/%02h (expected/actual)",
            want.status, out_bus.status, want.next_x, out_bus.next_cursor_x,
            want.rd, out_bus.read_data));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_FONT_LOADED;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_FONT_WR;
    in_bus.address   = '0;
    in_bus.font_data = '0;
    in_bus.char_code = '0;
    in_bus.cursor_x  = '0;
    in_bus.cursor_y  = '0;
    out_bus.ready    = 1'b0;
    foreach (font_mem[i]) font_mem[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: reset registers, no font loaded yet, frame comes up empty
    flow = FLOW_FREE;
    put_draw(32, 5, 0);
    put_read(0);
    put_read(FrameBytes - 1);
    put_read(4095);
    wait_drained();

    // two glyphs: 'A' with a jump that wraps the font end, 'B' empty with max advance
    write_reg(CFG_FONT_LOADED, 1);
    write_reg(CFG_FONT_HEIGHT, 8);
    write_reg(CFG_FIRST_CHAR, 65);
    write_reg(CFG_CHAR_COUNT, 2);
    put_font(4, 8'hFF);
    put_font(5, 8'hF2);
    put_font(6, 3);
    put_font(7, 8'hFF);
    put_font(4094, 8'h81);
    put_font(4095, 8'hFF);
    put_font(0, 8'h7E);
    put_font(8, 8'h00);
    put_font(9, 8'h00);
    put_font(10, 8'h00);
    put_font(11, 8'hFF);
    put_draw(65, 0, 0);       // lands in bytes 0, 4, 8
    put_draw(65, 1023, 3);    // off screen on the first byte
    put_draw(66, 1023, 0);    // cursor saturates
    put_draw(64, 0, 0);       // below the first character
    put_draw(67, 0, 0);       // one past the last character
    put_read(4);
    put_read(8);
    put_clear();
    put_read(4);

    // random phases across register extremes and traffic shapes
    run_phase(FLOW_FREE,      1, 8,   32,  95,  2, 25, 0,   0, 0);
    run_phase(FLOW_SRC_IDLE,  1, 64,  0,   255, 2, 20, 120, 0, 0);
    run_phase(FLOW_SNK_STALL, 1, 0,   255, 1,   1, 20, 0,   0, 0);
    run_phase(FLOW_BOTH,      1, 127, $urandom_range(255, 0), $urandom_range(255, 1),
              2, 25, 0, 1, 0);
    run_phase(FLOW_FREE,      1, 16,  48,  10,  2, 25, 0,   0, 1);
    run_phase(FLOW_BOTH,      0, 1,   0,   128, 1, 15, 0,   0, 0);
    run_phase(FLOW_SRC_IDLE,  1, $urandom_range(64, 1), $urandom_range(255, 0), 0,
              0, 15, 0, 0, 0);
    run_phase(FLOW_SNK_STALL, 1, 24,  97,  26,  2, 20, 0,   0, 0);

    // drain, then allow for a clear still running
    wait_drained();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("glyph_render_to_framebuffer_core verification clean");
    end else begin
      $display("glyph_render_to_framebuffer_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("glyph_render_to_framebuffer_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/grf_pkg.sv
rtl/core/grf_stream_if.sv
rtl/core/grf_ram.sv
rtl/core/grf_ctrl.sv
rtl/core/grf_dp.sv
rtl/core/glyph_render_to_framebuffer_core.sv
tb/tb_top.sv
